>>> design/etq_pkg.sv
package etq_pkg;

  // field widths and lane counts
  localparam int ANGLE_W = 16;
  localparam int QUAT_W  = 16;
  localparam int LANES   = 3;
  localparam int QUATS   = 4;

  // lane order for the three angles
  localparam int ROLL  = 0;
  localparam int PITCH = 1;
  localparam int YAW   = 2;

  // quaternion component order
  localparam int QW = 0;
  localparam int QX = 1;
  localparam int QY = 2;
  localparam int QZ = 3;

  // internal fixed point: 30 fractional bits
  localparam int WF     = 30;
  localparam int ROT_W  = 32;  // folded angle, sine, cosine, products
  localparam int CORD_W = 34;  // cordic x and y with headroom
  localparam int RES_W  = 33;  // cordic residual angle
  localparam int SUM_W  = 33;  // sum of two triple products

  localparam longint Q_PI        = 64'sd3373259426;
  localparam longint Q_HALF_PI   = 64'sd1686629713;
  localparam longint Q_TWO_PI    = 64'sd6746518852;
  localparam longint Q_FOLD_HI   = 64'sd5059889139;  // two pi less half pi
  localparam longint CORDIC_GAIN = 64'sd652032874;

  typedef logic signed [ROT_W-1:0]  rot_t;
  typedef logic signed [QUAT_W-1:0] quat_t;
  typedef logic signed [ANGLE_W-1:0] angle_t;

  // atan(2^-i) with 30 fractional bits
  localparam logic [29:0] ATAN_TAB [32] = '{
    30'd843314857, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515,  30'd16775850,  30'd8388437,   30'd4194282,   30'd2097149,
    30'd1048576,   30'd524288,    30'd262144,    30'd131072,    30'd65536,
    30'd32768,     30'd16384,     30'd8192,      30'd4096,      30'd2048,
    30'd1024,      30'd512,       30'd256,       30'd128,       30'd64,
    30'd32,        30'd16,        30'd8,         30'd4,         30'd2,
    30'd1,         30'd0
  };

  // fixed point product, round half up, floor shift
  function automatic rot_t qmul(rot_t a, rot_t b);
    logic signed [63:0] p;
    p = a * b + 64'sd536870912;
    return ROT_W'(p >>> WF);
  endfunction

  // output clamp limits for a given fraction width
  function automatic int out_hi(int frac_bits);
    int lim;
    lim = 1 << frac_bits;
    return (lim > 32767) ? 32767 : lim;
  endfunction

  function automatic int out_lo(int frac_bits);
    int lim;
    lim = 1 << frac_bits;
    return (lim > 32768) ? -32768 : -lim;
  endfunction

endpackage

>>> design/euler_to_quaternion_top.sv
// an input transfer passes the reduce, cordic and combine register stages, in that order,
//   on its way to output valid
// throughput: one transfer per cycle while the skid entry is empty, else the pipeline holds;
// one register stage per cordic step, all lanes in parallel; a two-entry output buffer keeps
// input ready high while one result waits; reset clears the valid bits only, no other state
module euler_to_quaternion_top #(
  parameter int ANGLE_FRAC_BITS = 13,
  parameter int OUT_FRAC_BITS   = 14,
  parameter int CORDIC_STEPS    = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [15:0]    roll_angle,
  input  logic signed [15:0]    pitch_angle,
  input  logic signed [15:0]    yaw_angle,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [15:0]    quat_w,
  output logic signed [15:0]    quat_x,
  output logic signed [15:0]    quat_y,
  output logic signed [15:0]    quat_z
);

  localparam int QuatHi = etq_pkg::out_hi(OUT_FRAC_BITS);
  localparam int QuatLo = etq_pkg::out_lo(OUT_FRAC_BITS);

  logic                  en;
  etq_pkg::angle_t       angle   [etq_pkg::LANES];
  etq_pkg::rot_t         rot     [etq_pkg::LANES];
  logic                  neg_cos [etq_pkg::LANES];
  logic                  red_valid;
  etq_pkg::rot_t         sin_v   [etq_pkg::LANES];
  etq_pkg::rot_t         cos_v   [etq_pkg::LANES];
  logic                  cor_valid;
  etq_pkg::quat_t        pipe_q  [etq_pkg::QUATS];
  logic                  pipe_valid;
  etq_pkg::quat_t        out_q   [etq_pkg::QUATS];
  etq_pkg::quat_t        skid_q  [etq_pkg::QUATS];
  logic                  skid_valid;

  // pipeline advances while the skid entry is free
  assign en       = ~skid_valid;
  assign in_ready = en;

  assign angle[etq_pkg::ROLL]  = roll_angle;
  assign angle[etq_pkg::PITCH] = pitch_angle;
  assign angle[etq_pkg::YAW]   = yaw_angle;

  etq_reduce #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_reduce (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .angle     (angle),
    .out_valid (red_valid),
    .rot       (rot),
    .neg_cos   (neg_cos)
  );

  etq_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (red_valid),
    .rot       (rot),
    .neg_cos   (neg_cos),
    .out_valid (cor_valid),
    .sin_o     (sin_v),
    .cos_o     (cos_v)
  );

  etq_combine #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_combine (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (cor_valid),
    .sin_i     (sin_v),
    .cos_i     (cos_v),
    .out_valid (pipe_valid),
    .quat      (pipe_q)
  );

  // output register and skid entry control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (pipe_valid) begin
      if (!out_valid || out_ready) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output and skid data
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_ready) begin
        out_q <= skid_q;
      end
    end else if (pipe_valid) begin
      if (!out_valid || out_ready) begin
        out_q <= pipe_q;
      end else begin
        skid_q <= pipe_q;
      end
    end
  end

  assign quat_w = out_q[etq_pkg::QW];
  assign quat_x = out_q[etq_pkg::QX];
  assign quat_y = out_q[etq_pkg::QY];
  assign quat_z = out_q[etq_pkg::QZ];

  // skid entry only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid without output valid");

  // a result leaving the pipeline into a stalled output lands in the skid entry
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && !skid_valid && pipe_valid) |=> skid_valid)
    else $error("result dropped at stalled output");

  // draining the skid entry keeps the output valid
  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_ready) |=> (out_valid && !skid_valid))
    else $error("skid entry not moved to output");

  // results stay inside the saturation limits
  a_quat_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (quat_w <= QuatHi && quat_w >= QuatLo &&
                   quat_x <= QuatHi && quat_x >= QuatLo &&
                   quat_y <= QuatHi && quat_y >= QuatLo &&
                   quat_z <= QuatHi && quat_z >= QuatLo))
    else $error("quaternion component outside saturation limits");

endmodule

>>> design/etq_reduce.sv
module etq_reduce #(
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  etq_pkg::angle_t       angle   [etq_pkg::LANES],
  output logic                  out_valid,
  output etq_pkg::rot_t         rot     [etq_pkg::LANES],
  output logic                  neg_cos [etq_pkg::LANES]
);

  localparam int Shift = etq_pkg::WF - 1 - ANGLE_FRAC_BITS;
  localparam int MagW  = (etq_pkg::ANGLE_W + Shift > 34) ? etq_pkg::ANGLE_W + Shift : 34;
  localparam int Qb    = (etq_pkg::ANGLE_W + Shift > 33) ? etq_pkg::ANGLE_W + Shift - 33 : 0;
  localparam int FoldW = 35;

  localparam logic signed [FoldW-1:0] HalfPi = FoldW'(etq_pkg::Q_HALF_PI);
  localparam logic signed [FoldW-1:0] Pi     = FoldW'(etq_pkg::Q_PI);
  localparam logic signed [FoldW-1:0] TwoPi  = FoldW'(etq_pkg::Q_TWO_PI);
  localparam logic signed [FoldW-1:0] FoldHi = FoldW'(etq_pkg::Q_FOLD_HI);

  logic [etq_pkg::ANGLE_W:0]  mag_in [etq_pkg::LANES];
  logic [MagW-1:0]            mag    [Qb+1][etq_pkg::LANES];
  logic                       sgn    [Qb+1][etq_pkg::LANES];
  logic                       vld    [Qb+1];

  logic signed [FoldW-1:0]    mm     [etq_pkg::LANES];
  logic signed [FoldW-1:0]    f_c    [etq_pkg::LANES];
  logic                       n_c    [etq_pkg::LANES];

  etq_pkg::rot_t              fold   [etq_pkg::LANES];
  logic                       fold_neg [etq_pkg::LANES];
  logic                       fold_sgn [etq_pkg::LANES];
  logic                       fold_vld;

  // magnitude of each input angle
  always_comb begin
    for (int l = 0; l < etq_pkg::LANES; l++) begin
      mag_in[l] = angle[l][etq_pkg::ANGLE_W-1] ?
                  -{angle[l][etq_pkg::ANGLE_W-1], angle[l]} :
                  {angle[l][etq_pkg::ANGLE_W-1], angle[l]};
    end
  end

  // input stage: half angle magnitude in Q30 and its sign
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < etq_pkg::LANES; l++) begin
        mag[0][l] <= MagW'(mag_in[l]) << Shift;
        sgn[0][l] <= angle[l][etq_pkg::ANGLE_W-1];
      end
    end
  end

  // restoring reduction modulo two pi, one quotient bit per stage
  for (genvar k = 0; k < Qb; k++) begin : g_mod
    localparam logic [MagW-1:0] Step = MagW'(etq_pkg::Q_TWO_PI << (Qb - 1 - k));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < etq_pkg::LANES; l++) begin
          mag[k+1][l] <= (mag[k][l] >= Step) ? mag[k][l] - Step : mag[k][l];
          sgn[k+1][l] <= sgn[k][l];
        end
      end
    end
  end

  // fold [0, 2pi) into [-pi/2, pi/2], flag a cosine sign flip
  always_comb begin
    for (int l = 0; l < etq_pkg::LANES; l++) begin
      mm[l] = $signed({1'b0, mag[Qb][l][FoldW-2:0]});
      if (mm[l] <= HalfPi) begin
        f_c[l] = mm[l];
        n_c[l] = 1'b0;
      end else if (mm[l] < FoldHi) begin
        f_c[l] = Pi - mm[l];
        n_c[l] = 1'b1;
      end else begin
        f_c[l] = mm[l] - TwoPi;
        n_c[l] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fold_vld <= 1'b0;
    end else if (en) begin
      fold_vld <= vld[Qb];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < etq_pkg::LANES; l++) begin
        fold[l]     <= f_c[l][etq_pkg::ROT_W-1:0];
        fold_neg[l] <= n_c[l];
        fold_sgn[l] <= sgn[Qb][l];
      end
    end
  end

  // restore the sign of the original angle
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= fold_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < etq_pkg::LANES; l++) begin
        rot[l]     <= fold_sgn[l] ? -fold[l] : fold[l];
        neg_cos[l] <= fold_neg[l];
      end
    end
  end

endmodule

>>> design/etq_cordic.sv
module etq_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  etq_pkg::rot_t rot     [etq_pkg::LANES],
  input  logic          neg_cos [etq_pkg::LANES],
  output logic          out_valid,
  output etq_pkg::rot_t sin_o   [etq_pkg::LANES],
  output etq_pkg::rot_t cos_o   [etq_pkg::LANES]
);

  localparam int CW = etq_pkg::CORD_W;
  localparam int RW = etq_pkg::RES_W;

  logic signed [CW-1:0] x   [CORDIC_STEPS+1][etq_pkg::LANES];
  logic signed [CW-1:0] y   [CORDIC_STEPS+1][etq_pkg::LANES];
  logic signed [RW-1:0] z   [CORDIC_STEPS+1][etq_pkg::LANES];
  logic                 ng  [CORDIC_STEPS+1][etq_pkg::LANES];
  logic                 vld [CORDIC_STEPS+1];
  logic signed [CW-1:0] neg_x [etq_pkg::LANES];

  // seed: x at the gain constant, y at zero, z at the angle
  assign vld[0] = in_valid;
  for (genvar l = 0; l < etq_pkg::LANES; l++) begin : g_seed
    assign x[0][l]  = CW'(etq_pkg::CORDIC_GAIN);
    assign y[0][l]  = '0;
    assign z[0][l]  = RW'(rot[l]);
    assign ng[0][l] = neg_cos[l];
  end

  // one rotation step per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [RW-1:0] AtanI = RW'(etq_pkg::ATAN_TAB[i]);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < etq_pkg::LANES; l++) begin
          if (!z[i][l][RW-1]) begin
            x[i+1][l] <= x[i][l] - (y[i][l] >>> i);
            y[i+1][l] <= y[i][l] + (x[i][l] >>> i);
            z[i+1][l] <= z[i][l] - AtanI;
          end else begin
            x[i+1][l] <= x[i][l] + (y[i][l] >>> i);
            y[i+1][l] <= y[i][l] - (x[i][l] >>> i);
            z[i+1][l] <= z[i][l] + AtanI;
          end
          ng[i+1][l] <= ng[i][l];
        end
      end
    end
  end

  // apply the cosine sign flip from the fold
  always_comb begin
    for (int l = 0; l < etq_pkg::LANES; l++) begin
      neg_x[l] = -x[CORDIC_STEPS][l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < etq_pkg::LANES; l++) begin
        sin_o[l] <= y[CORDIC_STEPS][l][etq_pkg::ROT_W-1:0];
        cos_o[l] <= ng[CORDIC_STEPS][l] ? neg_x[l][etq_pkg::ROT_W-1:0] :
                                          x[CORDIC_STEPS][l][etq_pkg::ROT_W-1:0];
      end
    end
  end

endmodule

>>> design/etq_combine.sv
module etq_combine #(
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  etq_pkg::rot_t  sin_i [etq_pkg::LANES],
  input  etq_pkg::rot_t  cos_i [etq_pkg::LANES],
  output logic           out_valid,
  output etq_pkg::quat_t quat  [etq_pkg::QUATS]
);

  localparam int RndW = etq_pkg::SUM_W + 1;
  localparam logic signed [RndW-1:0] Hi = RndW'(etq_pkg::out_hi(OUT_FRAC_BITS));
  localparam logic signed [RndW-1:0] Lo = RndW'(etq_pkg::out_lo(OUT_FRAC_BITS));

  etq_pkg::rot_t cc, ss, sc, cs, cy_d, sy_d;
  etq_pkg::rot_t prod [8];
  logic signed [etq_pkg::SUM_W-1:0] sum   [etq_pkg::QUATS];
  logic signed [RndW-1:0]           rnd_c [etq_pkg::QUATS];
  logic signed [RndW-1:0]           rnd   [etq_pkg::QUATS];
  logic v1, v2, v3;

  // valid bits follow the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  // roll and pitch pair products, yaw terms delayed alongside
  always_ff @(posedge clk) begin
    if (en) begin
      cc   <= etq_pkg::qmul(cos_i[etq_pkg::ROLL], cos_i[etq_pkg::PITCH]);
      ss   <= etq_pkg::qmul(sin_i[etq_pkg::ROLL], sin_i[etq_pkg::PITCH]);
      sc   <= etq_pkg::qmul(sin_i[etq_pkg::ROLL], cos_i[etq_pkg::PITCH]);
      cs   <= etq_pkg::qmul(cos_i[etq_pkg::ROLL], sin_i[etq_pkg::PITCH]);
      cy_d <= cos_i[etq_pkg::YAW];
      sy_d <= sin_i[etq_pkg::YAW];
    end
  end

  // triple products with yaw
  always_ff @(posedge clk) begin
    if (en) begin
      prod[0] <= etq_pkg::qmul(cc, cy_d);
      prod[1] <= etq_pkg::qmul(ss, sy_d);
      prod[2] <= etq_pkg::qmul(sc, cy_d);
      prod[3] <= etq_pkg::qmul(cs, sy_d);
      prod[4] <= etq_pkg::qmul(cs, cy_d);
      prod[5] <= etq_pkg::qmul(sc, sy_d);
      prod[6] <= etq_pkg::qmul(cc, sy_d);
      prod[7] <= etq_pkg::qmul(ss, cy_d);
    end
  end

  // zyx sums
  always_ff @(posedge clk) begin
    if (en) begin
      sum[etq_pkg::QW] <= etq_pkg::SUM_W'(prod[0]) + etq_pkg::SUM_W'(prod[1]);
      sum[etq_pkg::QX] <= etq_pkg::SUM_W'(prod[2]) - etq_pkg::SUM_W'(prod[3]);
      sum[etq_pkg::QY] <= etq_pkg::SUM_W'(prod[4]) + etq_pkg::SUM_W'(prod[5]);
      sum[etq_pkg::QZ] <= etq_pkg::SUM_W'(prod[6]) - etq_pkg::SUM_W'(prod[7]);
    end
  end

  // round to the output fraction width
  if (OUT_FRAC_BITS < etq_pkg::WF) begin : g_round
    localparam logic signed [RndW-1:0] Half =
      RndW'(64'sd1 << (etq_pkg::WF - 1 - OUT_FRAC_BITS));
    always_comb begin
      for (int q = 0; q < etq_pkg::QUATS; q++) begin
        rnd_c[q] = (RndW'(sum[q]) + Half) >>> (etq_pkg::WF - OUT_FRAC_BITS);
      end
    end
  end else begin : g_noround
    always_comb begin
      for (int q = 0; q < etq_pkg::QUATS; q++) begin
        rnd_c[q] = RndW'(sum[q]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int q = 0; q < etq_pkg::QUATS; q++) begin
        rnd[q] <= rnd_c[q];
      end
    end
  end

  // saturate to plus or minus one and the field range
  always_comb begin
    for (int q = 0; q < etq_pkg::QUATS; q++) begin
      if (rnd[q] > Hi) begin
        quat[q] = Hi[etq_pkg::QUAT_W-1:0];
      end else if (rnd[q] < Lo) begin
        quat[q] = Lo[etq_pkg::QUAT_W-1:0];
      end else begin
        quat[q] = rnd[q][etq_pkg::QUAT_W-1:0];
      end
    end
  end

endmodule

>>> bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ANGLE_FRAC    = 13;
  localparam int OUT_FRAC      = 14;
  localparam int STEPS         = 16;
  localparam int LATENCY       = 8 + STEPS + ((ANGLE_FRAC < 12) ? 12 - ANGLE_FRAC : 0);
  localparam int PERIOD        = 20;
  localparam int RANDOM_ITEMS  = 600;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int ANGLE_PI      = 25736;
  localparam int ANGLE_HALF_PI = 12868;

  typedef struct packed {
    etq_pkg::quat_t w;
    etq_pkg::quat_t x;
    etq_pkg::quat_t y;
    etq_pkg::quat_t z;
  } quat_rec_t;

  // predicts the zyx quaternion of each angle triple and checks results in order
  class quat_checker;
    quat_rec_t pending_quats[$];
    int mismatches;

    function new();
      mismatches = 0;
    endfunction

    // q30 product, round half up, floor shift
    function longint round_mul(longint a, longint b);
      return (a * b + (longint'(1) << (etq_pkg::WF - 1))) >>> etq_pkg::WF;
    endfunction

    // sine and cosine of half the angle, folded into +-pi/2 before the cordic
    function void half_sincos(etq_pkg::angle_t ang, output longint s, output longint c);
      longint r, x, y, nx;
      bit flip;
      r = longint'(ang) * (longint'(1) << (etq_pkg::WF - 1 - ANGLE_FRAC));
      r = r % etq_pkg::Q_TWO_PI;
      flip = 1'b0;
      if (r > etq_pkg::Q_PI) r = r - etq_pkg::Q_TWO_PI;
      if (r < -etq_pkg::Q_PI) r = r + etq_pkg::Q_TWO_PI;
      if (r > etq_pkg::Q_HALF_PI) begin
        r = etq_pkg::Q_PI - r;
        flip = 1'b1;
      end
      if (r < -etq_pkg::Q_HALF_PI) begin
        r = -etq_pkg::Q_PI - r;
        flip = 1'b1;
      end
      x = etq_pkg::CORDIC_GAIN;
      y = 0;
      for (int i = 0; i < STEPS && i < 32; i++) begin
        if (r >= 0) begin
          nx = x - (y >>> i);
          y  = y + (x >>> i);
          r  = r - longint'(etq_pkg::ATAN_TAB[i]);
        end else begin
          nx = x + (y >>> i);
          y  = y - (x >>> i);
          r  = r + longint'(etq_pkg::ATAN_TAB[i]);
        end
        x = nx;
      end
      s = y;
      c = flip ? -x : x;
    endfunction

    // q30 sum to output fraction, then clamp to unit and field range
    function etq_pkg::quat_t to_fix(longint v);
      longint lim;
      lim = longint'(1) << OUT_FRAC;
      if (OUT_FRAC < etq_pkg::WF)
        v = (v + (longint'(1) << (etq_pkg::WF - 1 - OUT_FRAC))) >>> (etq_pkg::WF - OUT_FRAC);
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return etq_pkg::quat_t'(v);
    endfunction

    function quat_rec_t euler_to_quat(etq_pkg::angle_t roll, etq_pkg::angle_t pitch,
                                      etq_pkg::angle_t yaw);
      longint sr, cr, sp, cp, sy, cy;
      longint cc, ss, sc, cs;
      quat_rec_t q;
      half_sincos(roll, sr, cr);
      half_sincos(pitch, sp, cp);
      half_sincos(yaw, sy, cy);
      cc = round_mul(cr, cp);
      ss = round_mul(sr, sp);
      sc = round_mul(sr, cp);
      cs = round_mul(cr, sp);
      q.w = to_fix(round_mul(cc, cy) + round_mul(ss, sy));
      q.x = to_fix(round_mul(sc, cy) - round_mul(cs, sy));
      q.y = to_fix(round_mul(cs, cy) + round_mul(sc, sy));
      q.z = to_fix(round_mul(cc, sy) - round_mul(ss, cy));
      return q;
    endfunction

    function void note_angles(etq_pkg::angle_t roll, etq_pkg::angle_t pitch,
                              etq_pkg::angle_t yaw);
      pending_quats.push_back(euler_to_quat(roll, pitch, yaw));
    endfunction

    function void check_quat(etq_pkg::quat_t w, etq_pkg::quat_t x, etq_pkg::quat_t y,
                             etq_pkg::quat_t z);
      quat_rec_t want;
      if (pending_quats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected quaternion transfer: w=%0d x=%0d y=%0d z=%0d", w, x, y, z);
        return;
      end
      want = pending_quats.pop_front();
      if (want.w !== w || want.x !== x || want.y !== y || want.z !== z) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"quaternion mismatch: expected w=%0d x=%0d y=%0d z=%0d, ",
                    "got w=%0d x=%0d y=%0d z=%0d"},
                   want.w, want.x, want.y, want.z, w, x, y, z);
      end
    endfunction
  endclass

  logic            clk         = 1'b0;
  logic            rst         = 1'b1;
  logic            in_valid    = 1'b0;
  logic            in_ready;
  etq_pkg::angle_t roll_angle  = '0;
  etq_pkg::angle_t pitch_angle = '0;
  etq_pkg::angle_t yaw_angle   = '0;
  logic            out_valid;
  logic            out_ready   = 1'b0;
  etq_pkg::quat_t  quat_w, quat_x, quat_y, quat_z;

  quat_checker quat_chk = new();
  int send_calm = 0;
  int recv_calm = 0;
  int cycles = 0;

  euler_to_quaternion_top #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC),
    .OUT_FRAC_BITS(OUT_FRAC),
    .CORDIC_STEPS(STEPS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .roll_angle(roll_angle),
    .pitch_angle(pitch_angle),
    .yaw_angle(yaw_angle),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .quat_w(quat_w),
    .quat_x(quat_x),
    .quat_y(quat_y),
    .quat_z(quat_z)
  );

  always #(PERIOD / 2) clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // idle cycles before the next transfer, with runs of back-to-back transfers
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  // mostly in range, some raw bit patterns, some near plus or minus pi and half pi
  function automatic etq_pkg::angle_t random_angle();
    int pick;
    int sign;
    pick = $urandom_range(0, 19);
    sign = $urandom_range(0, 1) ? 1 : -1;
    if (pick < 16)
      return etq_pkg::angle_t'(int'($urandom_range(0, 2 * ANGLE_PI)) - ANGLE_PI);
    if (pick < 18) return etq_pkg::angle_t'($urandom());
    if (pick == 18)
      return etq_pkg::angle_t'(sign * (ANGLE_PI + int'($urandom_range(0, 6)) - 3));
    return etq_pkg::angle_t'(sign * (ANGLE_HALF_PI + int'($urandom_range(0, 6)) - 3));
  endfunction

  // one input transfer; entered and left at a falling edge
  task automatic send_angles(etq_pkg::angle_t roll, etq_pkg::angle_t pitch,
                             etq_pkg::angle_t yaw);
    int gap;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    roll_angle  <= roll;
    pitch_angle <= pitch;
    yaw_angle   <= yaw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    quat_chk.note_angles(roll, pitch, yaw);
    @(negedge clk);
  endtask

  // hold off the sender until every outstanding quaternion is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (quat_chk.pending_quats.size() != 0) @(negedge clk);
  endtask

  // result side with random back-pressure
  initial begin : result_sink
    int gap;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      gap = draw_gap(recv_calm);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      quat_chk.check_quat(quat_w, quat_x, quat_y, quat_z);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // identity, single axes at the range ends, and all axes at half pi
    send_angles(0, 0, 0);
    send_angles(ANGLE_PI, 0, 0);
    send_angles(0, ANGLE_PI, 0);
    send_angles(0, 0, ANGLE_PI);
    send_angles(-ANGLE_PI, 0, 0);
    send_angles(0, -ANGLE_PI, 0);
    send_angles(0, 0, -ANGLE_PI);
    send_angles(ANGLE_HALF_PI, ANGLE_HALF_PI, ANGLE_HALF_PI);
    send_angles(-ANGLE_HALF_PI, ANGLE_HALF_PI, -ANGLE_HALF_PI);
    // gimbal lock: pitch at plus and minus half pi
    send_angles(3000, ANGLE_HALF_PI, -7000);
    send_angles(-3000, -ANGLE_HALF_PI, 7000);
    // all extremes together
    send_angles(ANGLE_PI, -ANGLE_PI, ANGLE_PI);
    send_angles(-ANGLE_PI, -ANGLE_PI, -ANGLE_PI);
    // just past pi, where the half angle folds over
    send_angles(ANGLE_PI + 1, -ANGLE_PI - 1, ANGLE_PI + 1);
    // raw bit patterns beyond the nominal range
    send_angles(32767, 32767, 32767);
    send_angles(-32768, -32768, -32768);
    send_angles(32767, -32768, 16'sh4000);
    // smallest steps either side of zero, then a mixed triple
    send_angles(1, -1, 1);
    send_angles(-1, 1, -1);
    send_angles(ANGLE_PI, ANGLE_HALF_PI, -ANGLE_HALF_PI);

    // random triples, with one full drain half way through
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) wait_drained();
      send_angles(random_angle(), random_angle(), random_angle());
    end

    // let the pipeline empty, then watch for stray results
    wait_drained();
    repeat (2 * LATENCY) @(negedge clk);
    if (quat_chk.mismatches == 0 && quat_chk.pending_quats.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
design/etq_pkg.sv
design/etq_reduce.sv
design/etq_cordic.sv
design/etq_combine.sv
design/euler_to_quaternion_top.sv
bench/tb_top.sv
